// File: rtl/core/madtw_pkg.sv
package madtw_pkg;

  // Offset and length width inside the table walk
  localparam int OFFSET_BITS = 16;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [31:0]            tlen_t;

  localparam off_t        HDR_END   = off_t'(44);
  localparam logic [14:0] TALLY_MAX = 15'h7fff;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  localparam logic [7:0] TYPE_OVERRIDE = 8'd2;

  // Result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;

  typedef struct packed {
    logic        kind;
    logic [1:0]  entry_type;
    logic [7:0]  entry_length;
    logic [15:0] entry_offset;
    logic [1:0]  walk_status;
    logic [14:0] ovr_count;
    logic        last;
  } res_t;

  // Up to two results per byte; r0 is written first
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// File: rtl/core/madtw_step.sv
module madtw_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_first,
  input  logic             room,
  output madtw_pkg::push_t push
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEAD, PH_TYPE, PH_LEN, PH_BODY, PH_DONE
  } phase_t;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first;

  // Walk state
  phase_t            phase;
  madtw_pkg::off_t   byte_offset;
  madtw_pkg::tlen_t  table_length;
  madtw_pkg::off_t   next_entry_start;
  logic [7:0]        current_type;
  logic [14:0]       override_tally;

  phase_t            phase_next;
  madtw_pkg::off_t   byte_offset_next;
  madtw_pkg::tlen_t  table_length_next;
  madtw_pkg::off_t   next_entry_start_next;
  logic [7:0]        current_type_next;
  logic [14:0]       override_tally_next;

  logic fire;
  logic ent_valid;
  logic fin_valid;
  logic [1:0] fin_status;
  logic [32:0] rec_end;
  madtw_pkg::off_t p;
  madtw_pkg::res_t ent;
  madtw_pkg::res_t fin;

  assign fire     = s1_valid && room;
  assign in_ready = !s1_valid || fire;

  always_comb begin
    phase_next            = s1_first ? PH_HEAD : phase;
    byte_offset_next      = s1_first ? '0 : byte_offset;
    table_length_next     = s1_first ? '0 : table_length;
    next_entry_start_next = s1_first ? madtw_pkg::HDR_END : next_entry_start;
    current_type_next     = s1_first ? 8'd0 : current_type;
    override_tally_next   = s1_first ? 15'd0 : override_tally;
    ent_valid  = 1'b0;
    fin_valid  = 1'b0;
    fin_status = madtw_pkg::ST_OK;
    rec_end    = 33'(next_entry_start_next) + 33'(s1_byte);
    p          = byte_offset_next;

    if (phase_next != PH_IDLE && phase_next != PH_DONE) begin
      unique case (phase_next)
        PH_HEAD: begin
          if (p[madtw_pkg::OFFSET_BITS-1:3] == '0 && p[2]) begin
            case (p[1:0])
              2'd0:    table_length_next[7:0]   = table_length_next[7:0]   | s1_byte;
              2'd1:    table_length_next[15:8]  = table_length_next[15:8]  | s1_byte;
              2'd2:    table_length_next[23:16] = table_length_next[23:16] | s1_byte;
              default: table_length_next[31:24] = table_length_next[31:24] | s1_byte;
            endcase
          end
          if (p == madtw_pkg::off_t'(7)) begin
            if (table_length_next < 32'(madtw_pkg::HDR_END)) begin
              fin_valid  = 1'b1;
              fin_status = madtw_pkg::ST_SHORT;
              phase_next = PH_DONE;
            end else if ((table_length_next >> madtw_pkg::OFFSET_BITS) != 32'd0) begin
              fin_valid  = 1'b1;
              fin_status = madtw_pkg::ST_TOO_LARGE;
              phase_next = PH_DONE;
            end
          end else if (p == madtw_pkg::HDR_END - madtw_pkg::off_t'(1)) begin
            if (33'(next_entry_start_next) + 33'd2 > 33'(table_length_next)) begin
              fin_valid  = 1'b1;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          current_type_next = s1_byte;
          phase_next        = PH_LEN;
        end
        PH_LEN: begin
          if (s1_byte < 8'd2 || rec_end > 33'(table_length_next)) begin
            fin_valid  = 1'b1;
            fin_status = madtw_pkg::ST_MALFORMED;
            phase_next = PH_DONE;
          end else begin
            if (current_type_next <= 8'd2) begin
              if (current_type_next == madtw_pkg::TYPE_OVERRIDE &&
                  override_tally_next != madtw_pkg::TALLY_MAX) begin
                override_tally_next = override_tally_next + 15'd1;
              end
              ent_valid = 1'b1;
            end
            next_entry_start_next = madtw_pkg::off_t'(rec_end);
            phase_next            = PH_BODY;
          end
        end
        default: ;
      endcase

      // Byte before the next record start: close the walk or expect a type
      if (phase_next == PH_BODY && 33'(p) + 33'd1 == 33'(next_entry_start_next)) begin
        if (33'(next_entry_start_next) + 33'd2 > 33'(table_length_next)) begin
          fin_valid  = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_TYPE;
        end
      end

      byte_offset_next = p + madtw_pkg::off_t'(1);
    end
  end

  always_comb begin
    ent                = '0;
    ent.kind           = madtw_pkg::KIND_ENTRY;
    ent.entry_type     = current_type_next[1:0];
    ent.entry_length   = s1_byte;
    ent.entry_offset   = 16'(32'(next_entry_start));
    ent.ovr_count      = override_tally_next;
    ent.last           = !fin_valid;

    fin                = '0;
    fin.kind           = madtw_pkg::KIND_DONE;
    fin.walk_status    = fin_status;
    fin.ovr_count      = override_tally_next;
    fin.last           = 1'b1;

    push    = '0;
    push.r0 = ent_valid ? ent : fin;
    push.r1 = fin;
    if (fire) begin
      push.n = 2'(ent_valid) + 2'(fin_valid);
    end
  end

  // The entry offset is the start before this record's length was added
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      phase            <= PH_IDLE;
      byte_offset      <= '0;
      table_length     <= '0;
      next_entry_start <= madtw_pkg::HDR_END;
      current_type     <= 8'd0;
      override_tally   <= 15'd0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (fire) begin
        phase            <= phase_next;
        byte_offset      <= byte_offset_next;
        table_length     <= table_length_next;
        next_entry_start <= next_entry_start_next;
        current_type     <= current_type_next;
        override_tally   <= override_tally_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_byte  <= in_byte;
      s1_first <= in_first;
    end
  end

  a_no_push_unless_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |-> push.n == 2'd0)
    else $error("results pushed without a processed byte");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> push.r0.kind == madtw_pkg::KIND_ENTRY &&
                      push.r1.kind == madtw_pkg::KIND_DONE && !push.r0.last)
    else $error("two results from one byte out of order");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_DONE && !s1_first |-> push.n == 2'd0)
    else $error("result after the walk finished");

endmodule

// File: rtl/core/madtw_out_fifo.sv
module madtw_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  madtw_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output madtw_pkg::res_t  out_res
);

  madtw_pkg::res_t mem [madtw_pkg::RQ_DEPTH];

  logic [madtw_pkg::RQ_AW-1:0] wr_ptr;
  logic [madtw_pkg::RQ_AW-1:0] rd_ptr;
  logic [madtw_pkg::RQ_AW:0]   count;
  logic                        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_res   = mem[rd_ptr];
  // Room for the worst case of two results from one byte
  assign room      = count <= (madtw_pkg::RQ_AW+1)'(madtw_pkg::RQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + madtw_pkg::RQ_AW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + madtw_pkg::RQ_AW'(1);
      end
      count <= count + (madtw_pkg::RQ_AW+1)'(push.n) - (madtw_pkg::RQ_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + madtw_pkg::RQ_AW'(1)] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (madtw_pkg::RQ_AW+1)'(madtw_pkg::RQ_DEPTH))
    else $error("result queue overflow");

endmodule

// File: rtl/core/madt_entry_walker_top.sv
// Channel | Dir | Payload
// s_*     | in  | tdata[7:0] data_byte; tuser first_byte
// m_*     | out | tdata entry_type..ovr_count; tuser kind; tlast last
//
// One table byte per cycle enters an input register; the walk step is
// applied as it leaves that register and its results go into a four-entry
// result queue. A length byte that ends both a two-byte record and the table
// gives two results, an entry and a done result; the queue takes both at once.
// Input stalls only when the queue has fewer than two free slots.
// After rst the walker is idle until a beat with first_byte set.
module madt_entry_walker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] first_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [1:0] entry_type, [9:2] entry_length,
                                 // [25:10] entry_offset, [27:26] walk_status,
                                 // [42:28] ovr_count, [47:43] zero
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast
);

  madtw_pkg::push_t push;
  madtw_pkg::res_t  res;
  logic             room;

  madtw_step u_step (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_first (s_tuser),
    .room     (room),
    .push     (push)
  );

  madtw_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {5'd0, res.ovr_count, res.walk_status, res.entry_offset,
                    res.entry_length, res.entry_type};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

// File: bench/madt_walk_checker.sv
`timescale 1ns / 1ps

module madt_walk_checker
  import madtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          pending,
  output int          mismatches
);

  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_HEAD,
    WALK_TYPE,
    WALK_LEN,
    WALK_BODY,
    WALK_DONE
  } walk_phase_e;

  // shadow walk state
  logic [15:0]  pos;
  logic [31:0]  tbl_len;
  logic [31:0]  rec_start;
  logic [7:0]   rec_type;
  logic [14:0]  ovr_tally;
  walk_phase_e  phase;

  res_t step_res [2];
  int   step_n;
  res_t expected_reports [$];
  int   miss_n;

  task automatic restart_walk;
    pos       = '0;
    tbl_len   = '0;
    rec_start = {16'd0, HDR_END};
    rec_type  = '0;
    ovr_tally = '0;
  endtask

  task automatic emit(input logic kind, input logic [1:0] ty, input logic [7:0] len,
                      input logic [15:0] off, input logic [1:0] st);
    res_t r;
    r.kind           = kind;
    r.entry_type     = ty;
    r.entry_length   = len;
    r.entry_offset   = off;
    r.walk_status    = st;
    r.ovr_count      = ovr_tally;
    r.last           = 1'b0;
    step_res[step_n] = r;
    step_n++;
  endtask

  task automatic close_table(input logic [1:0] st);
    emit(KIND_DONE, 2'd0, 8'd0, 16'd0, st);
    phase = WALK_DONE;
  endtask

  // next byte starts a record; fewer than two bytes left ends the walk
  task automatic at_record_start;
    if ({1'b0, rec_start} + 33'd2 > {1'b0, tbl_len}) begin
      close_table(ST_OK);
    end else begin
      phase = WALK_TYPE;
    end
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic first);
    logic [32:0] rec_end;
    res_t        r;
    int          i;
    step_n = 0;
    if (first) begin
      restart_walk();
      phase = WALK_HEAD;
    end
    if (phase != WALK_IDLE && phase != WALK_DONE) begin
      case (phase)
        WALK_HEAD: begin
          if (pos >= 16'd4 && pos <= 16'd7)
            tbl_len = tbl_len | ({24'd0, b} << (8 * (pos - 16'd4)));
          if (pos == 16'd7) begin
            if (tbl_len < {16'd0, HDR_END})
              close_table(ST_SHORT);
            else if (tbl_len > (32'd1 << OFFSET_BITS) - 32'd1)
              close_table(ST_TOO_LARGE);
          end else if (pos == HDR_END - 16'd1) begin
            at_record_start();
          end
        end
        WALK_TYPE: begin
          rec_type = b;
          phase    = WALK_LEN;
        end
        WALK_LEN: begin
          rec_end = {1'b0, rec_start} + {25'd0, b};
          if (b < 8'd2 || rec_end > {1'b0, tbl_len}) begin
            close_table(ST_MALFORMED);
          end else begin
            if (rec_type <= TYPE_OVERRIDE) begin
              if (rec_type == TYPE_OVERRIDE && ovr_tally != TALLY_MAX)
                ovr_tally = ovr_tally + 15'd1;
              emit(KIND_ENTRY, rec_type[1:0], b, rec_start[15:0], ST_OK);
            end
            rec_start = rec_end[31:0];
            phase     = WALK_BODY;
          end
        end
        default: ;
      endcase
      if (phase == WALK_BODY && {16'd0, pos} + 32'd1 == rec_start)
        at_record_start();
      pos = pos + 16'd1;
    end
    for (i = 0; i < step_n; i++) begin
      r      = step_res[i];
      r.last = (i == step_n - 1);
      expected_reports.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    if (rst) begin
      restart_walk();
      phase = WALK_IDLE;
      expected_reports.delete();
      miss_n = 0;
    end else begin
      // compare first: a beat leaving now never belongs to a byte entering now
      if (m_tvalid && m_tready) begin
        seen = {m_tuser, m_tdata[1:0], m_tdata[9:2], m_tdata[25:10], m_tdata[27:26],
                m_tdata[42:28], m_tlast};
        if (expected_reports.size() == 0) begin
          miss_n++;
          if (miss_n <= 10)
            $display("%0t: unexpected beat k=%0d t=%0d len=%0d off=%0d st=%0d ovr=%0d last=%0d",
                     $time, seen.kind, seen.entry_type, seen.entry_length, seen.entry_offset,
                     seen.walk_status, seen.ovr_count, seen.last);
        end else begin
          want = expected_reports.pop_front();
          if (seen != want || m_tdata[47:43] != 5'd0) begin
            miss_n++;
            if (miss_n <= 10)
              $display({"%0t: beat mismatch exp k=%0d t=%0d len=%0d off=%0d st=%0d ovr=%0d ",
                        "last=%0d | got k=%0d t=%0d len=%0d off=%0d st=%0d ovr=%0d last=%0d ",
                        "pad=%0h"},
                       $time, want.kind, want.entry_type, want.entry_length,
                       want.entry_offset, want.walk_status, want.ovr_count, want.last,
                       seen.kind, seen.entry_type, seen.entry_length, seen.entry_offset,
                       seen.walk_status, seen.ovr_count, seen.last, m_tdata[47:43]);
          end
        end
      end
      if (s_tvalid && s_tready)
        walk_byte(s_tdata, s_tuser);
    end
    pending    <= expected_reports.size();
    mismatches <= miss_n;
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import madtw_pkg::*;

  localparam logic [7:0] REC_LAPIC  = 8'd0;
  localparam logic [7:0] REC_IOAPIC = 8'd1;
  localparam logic [7:0] REC_OTHER  = 8'd200;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int BYTE_TARGET    = 1350;
  localparam int QUIET_FROM     = 1150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int pending;
  int mismatches;
  int idle_pct = 15;
  int stall_left = 0;
  int stuck = 0;
  int counted = 0;

  logic [7:0] tbl [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  madt_entry_walker_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  madt_walk_checker walk_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // receiver back-pressure in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck <= 0;
    end else if (stuck >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic send_beat(input logic [7:0] d, input logic first);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic push_header(input logic [31:0] len);
    int i;
    tbl.delete();
    for (i = 0; i < 4; i++) tbl.push_back(8'($urandom));
    for (i = 0; i < 4; i++) tbl.push_back(len[8*i +: 8]);
    for (i = 8; i < 44; i++) tbl.push_back(8'($urandom));
  endtask

  task automatic seal_length(input logic [31:0] len);
    int i;
    for (i = 0; i < 4; i++) tbl[4+i] = len[8*i +: 8];
  endtask

  task automatic push_record(input logic [7:0] ty, input logic [7:0] len);
    int i;
    tbl.push_back(ty);
    tbl.push_back(len);
    for (i = 2; i < len; i++) tbl.push_back(8'($urandom));
  endtask

  task automatic pad_to(input int n);
    while (tbl.size() < n) tbl.push_back(8'($urandom));
  endtask

  // first cut bytes of the table, the first one flagged
  task automatic send_table(input int cut);
    int i;
    for (i = 0; i < cut && i < tbl.size(); i++) begin
      send_beat(tbl[i], i == 0);
      counted++;
    end
  endtask

  // let the last accepted beat reach the checker's count before waiting on it
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // header followed by random records, mostly known types
  task automatic build_records(input int nrec);
    int         i;
    logic [7:0] ty;
    logic [7:0] len;
    push_header(32'd0);
    for (i = 0; i < nrec; i++) begin
      ty  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(3, 255))
                                         : 8'($urandom_range(0, 2));
      len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(17, 255))
                                          : 8'($urandom_range(2, 16));
      push_record(ty, len);
    end
  endtask

  task automatic random_table;
    int          pick;
    int          s;
    int          lim;
    logic [31:0] len;
    logic [7:0]  bad;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        push_header(32'($urandom_range(0, 43)));
        send_table($urandom_range(8, 12));
      end
      1: begin
        len = $urandom;
        if (len[31:16] == 16'd0) len[16 + $urandom_range(0, 15)] = 1'b1;
        push_header(len);
        send_table($urandom_range(8, 10));
      end
      2, 3: begin
        build_records($urandom_range(0, 3));
        s   = tbl.size();
        lim = s + 2 + $urandom_range(0, 20);
        if ($urandom_range(0, 1) == 0)
          bad = 8'($urandom_range(0, 1));
        else
          bad = 8'($urandom_range(lim - s + 1, 255));
        tbl.push_back(8'($urandom));
        tbl.push_back(bad);
        pad_to(lim);
        seal_length(32'(lim));
        send_table(tbl.size());
      end
      4: begin
        build_records($urandom_range(1, 6));
        seal_length(32'(tbl.size()));
        send_table($urandom_range(1, tbl.size() - 1));
      end
      default: begin
        build_records($urandom_range(1, 6));
        pad_to(tbl.size() + $urandom_range(0, 1));
        seal_length(32'(tbl.size()));
        send_table(tbl.size());
      end
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // idle walker ignores unflagged bytes
    send_beat(8'h00, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'($urandom), 1'b0);

    // header only, exact minimum length
    push_header(32'd44);
    send_table(tbl.size());
    // too short, then ignored bytes
    push_header(32'd43);
    send_table(10);
    push_header(32'd0);
    send_table(8);
    // length beyond the offset width
    push_header(32'h0001_0000);
    send_table(9);
    push_header(32'hffff_ffff);
    send_table(8);

    // every reported type, skipped types, two-byte record closing the table
    push_header(32'd0);
    push_record(REC_LAPIC, 8'd8);
    push_record(REC_IOAPIC, 8'd12);
    push_record(TYPE_OVERRIDE, 8'd10);
    push_record(REC_OTHER, 8'd5);
    push_record(8'hff, 8'd2);
    push_record(TYPE_OVERRIDE, 8'd2);
    seal_length(32'(tbl.size()));
    send_table(tbl.size());

    // one byte left after the last record, plus a byte after the end
    push_header(32'd0);
    push_record(TYPE_OVERRIDE, 8'd3);
    pad_to(tbl.size() + 1);
    seal_length(32'(tbl.size()));
    pad_to(tbl.size() + 1);
    send_table(tbl.size());

    push_header(32'd45);
    pad_to(45);
    send_table(tbl.size());

    push_header(32'd46);
    push_record(REC_IOAPIC, 8'd2);
    send_table(tbl.size());

    // bad record lengths
    push_header(32'd0);
    push_record(REC_LAPIC, 8'd6);
    push_record(TYPE_OVERRIDE, 8'd0);
    pad_to(tbl.size() + 4);
    seal_length(32'(tbl.size()));
    send_table(tbl.size());

    push_header(32'd0);
    push_record(REC_IOAPIC, 8'd1);
    pad_to(tbl.size() + 3);
    seal_length(32'(tbl.size()));
    send_table(tbl.size());

    push_header(32'd54);
    push_record(REC_IOAPIC, 8'd20);
    send_table(54);

    // restart in the middle of a record body
    push_header(32'd0);
    push_record(REC_LAPIC, 8'd30);
    seal_length(32'(tbl.size()));
    send_table(60);

    // largest table length, largest records, cut short by the next table
    push_header(32'd65535);
    push_record(REC_LAPIC, 8'd255);
    push_record(REC_IOAPIC, 8'd255);
    push_record(TYPE_OVERRIDE, 8'd2);
    send_table(tbl.size());

    // restart inside the header
    push_header(32'd100);
    send_table(5);

    drain();

    while (counted < BYTE_TARGET) begin
      if (counted >= QUIET_FROM)
        idle_pct <= 0;
      else
        idle_pct <= ($urandom_range(0, 3) == 0) ? 0 : 15;
      random_table();
      if (counted >= BYTE_TARGET / 2 && counted < BYTE_TARGET / 2 + 150)
        drain();
    end

    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/madtw_pkg.sv
rtl/core/madtw_step.sv
rtl/core/madtw_out_fifo.sv
rtl/core/madt_entry_walker_top.sv
bench/madt_walk_checker.sv
bench/testbench.sv
